@@ sv/accumulator_machine_step_top_assert.svh @@
// Assertion macros used by the accumulator machine controller.
`ifndef ACCUMULATOR_MACHINE_STEP_TOP_ASSERT_SVH
`define ACCUMULATOR_MACHINE_STEP_TOP_ASSERT_SVH

// Same-cycle implication.
`define AMT_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("amt: same-cycle check failed");

// Next-cycle implication.
`define AMT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("amt: next-cycle check failed");

`endif

@@ sv/amt_pkg.sv @@
// Types and constants shared by the accumulator machine modules.
package amt_pkg;

  localparam logic [2:0] KIND_PWRITE = 3'd0;
  localparam logic [2:0] KIND_DWRITE = 3'd1;
  localparam logic [2:0] KIND_DREAD  = 3'd2;
  localparam logic [2:0] KIND_START  = 3'd3;
  localparam logic [2:0] KIND_STEP   = 3'd4;

  localparam logic [7:0] OP_NOP   = 8'd0;
  localparam logic [7:0] OP_LDI   = 8'd1;
  localparam logic [7:0] OP_LOAD  = 8'd2;
  localparam logic [7:0] OP_STORE = 8'd3;
  localparam logic [7:0] OP_INC   = 8'd4;
  localparam logic [7:0] OP_DEC   = 8'd5;
  localparam logic [7:0] OP_JMP   = 8'd6;
  localparam logic [7:0] OP_JLE   = 8'd7;
  localparam logic [7:0] OP_HALT  = 8'd8;

  localparam logic [2:0] STOP_RUN     = 3'd0;
  localparam logic [2:0] STOP_HALT    = 3'd1;
  localparam logic [2:0] STOP_BADOP   = 3'd2;
  localparam logic [2:0] STOP_NEGJ    = 3'd3;
  localparam logic [2:0] STOP_BADADDR = 3'd4;
  localparam logic [2:0] STOP_PAST    = 3'd5;

  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] PLEN_RESET = 9'd256;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         address;
    logic [7:0]         opcode;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] accumulator;
    logic [7:0]         program_counter;
    logic               halted;
    logic [2:0]         stop_status;
    logic signed [31:0] read_data;
  } rsp_item_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic exec;
    logic load_rd;
    logic load_wr;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_load;
  } sts_t;

endpackage

@@ sv/amt_req_if.sv @@
// Request channel: valid, ready and one input item.
interface amt_req_if;
  import amt_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

@@ sv/amt_rsp_if.sv @@
// Response channel: valid, ready and one result item.
interface amt_rsp_if;
  import amt_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

@@ sv/amt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module amt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/amt_dpath.sv @@
// Datapath: machine registers, program and data memories, result register.
module amt_dpath #(
  parameter int PROGRAM_DEPTH = 256,
  parameter int DATA_DEPTH    = 256,
  parameter int WORD_WIDTH    = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  amt_pkg::cmd_t               cmd,
  output amt_pkg::sts_t               sts,
  input  amt_pkg::req_item_t          req_item,
  input  logic                        cfg_we,
  input  logic [amt_pkg::CFG_W-1:0]   cfg_wdata,
  output amt_pkg::rsp_item_t          rsp_item
);
  import amt_pkg::*;

  localparam int AW_P = $clog2(PROGRAM_DEPTH);
  localparam int AW_D = $clog2(DATA_DEPTH);
  localparam int PCW  = $clog2(PROGRAM_DEPTH + 1);
  localparam int LW   = (PCW > CFG_W) ? PCW : CFG_W;
  localparam int CW   = (WORD_WIDTH > LW) ? WORD_WIDTH : LW;
  localparam int DCW  = (WORD_WIDTH > 18) ? WORD_WIDTH : 18;
  localparam int PWW  = 8 + WORD_WIDTH;

  req_item_t             item_q;
  logic [WORD_WIDTH-1:0] acc;
  logic [PCW-1:0]        pc;
  logic                  halted;
  logic [2:0]            status;
  logic [CFG_W-1:0]      plen;
  logic [AW_D-1:0]       clr_cnt;

  logic [WORD_WIDTH-1:0] acc_next;
  logic [PCW-1:0]        pc_next;
  logic                  halted_next;
  logic [2:0]            status_next;
  logic [31:0]           rd_next;

  logic [PWW-1:0]        pm_rdata;
  logic                  pm_we;
  logic [WORD_WIDTH-1:0] dm_rdata;
  logic                  dm_we;
  logic [AW_D-1:0]       dm_waddr;
  logic [WORD_WIDTH-1:0] dm_wdata;
  logic [AW_D-1:0]       dm_raddr;

  logic [WORD_WIDTH-1:0] val_w;
  logic [7:0]            op;
  logic [WORD_WIDTH-1:0] arg;
  logic [LW-1:0]         eff_len;
  logic [LW-1:0]         tgt;
  logic                  pc_ok;
  logic                  arg_ok;
  logic                  p_in_range;
  logic                  d_in_range;
  logic                  store_ok;
  logic                  need_load;

  assign val_w      = WORD_WIDTH'(item_q.value);
  assign op         = pm_rdata[PWW-1:WORD_WIDTH];
  assign arg        = pm_rdata[WORD_WIDTH-1:0];
  assign eff_len    = (LW'(plen) > LW'(PROGRAM_DEPTH)) ? LW'(PROGRAM_DEPTH) : LW'(plen);
  assign pc_ok      = LW'(pc) < eff_len;
  assign arg_ok     = !arg[WORD_WIDTH-1] && (DCW'(arg) < DCW'(DATA_DEPTH));
  assign tgt        = (CW'(arg) >= CW'(eff_len)) ? eff_len : LW'(arg);
  assign p_in_range = 32'(item_q.address) < PROGRAM_DEPTH;
  assign d_in_range = 32'(item_q.address) < DATA_DEPTH;

  always_comb begin
    acc_next    = acc;
    pc_next     = pc;
    halted_next = halted;
    status_next = status;
    rd_next     = '0;
    store_ok    = 1'b0;
    need_load   = 1'b0;
    case (item_q.kind)
      KIND_DREAD: begin
        rd_next = d_in_range ? 32'(dm_rdata) : '0;
      end
      KIND_START: begin
        acc_next    = val_w;
        pc_next     = '0;
        halted_next = 1'b0;
        status_next = STOP_RUN;
      end
      KIND_STEP: begin
        if (!halted) begin
          if (!pc_ok) begin
            halted_next = 1'b1;
            status_next = STOP_PAST;
          end else begin
            unique case (op)
              OP_NOP: pc_next = pc + PCW'(1);
              OP_LDI: begin
                acc_next = arg;
                pc_next  = pc + PCW'(1);
              end
              OP_LOAD, OP_STORE: begin
                if (!arg_ok) begin
                  halted_next = 1'b1;
                  status_next = STOP_BADADDR;
                end else if (op == OP_LOAD) begin
                  need_load = 1'b1;
                end else begin
                  store_ok = 1'b1;
                  pc_next  = pc + PCW'(1);
                end
              end
              OP_INC: begin
                acc_next = acc + WORD_WIDTH'(1);
                pc_next  = pc + PCW'(1);
              end
              OP_DEC: begin
                acc_next = acc - WORD_WIDTH'(1);
                pc_next  = pc + PCW'(1);
              end
              OP_JMP, OP_JLE: begin
                if (arg[WORD_WIDTH-1]) begin
                  halted_next = 1'b1;
                  status_next = STOP_NEGJ;
                end else if (op == OP_JMP || acc[WORD_WIDTH-1] || acc == '0) begin
                  pc_next = PCW'(tgt);
                end else begin
                  pc_next = pc + PCW'(1);
                end
              end
              OP_HALT: begin
                halted_next = 1'b1;
                status_next = STOP_HALT;
              end
              default: begin
                halted_next = 1'b1;
                status_next = STOP_BADOP;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    // load-from-memory finishes in the S_LOAD state with the data word
    if (cmd.load_wr) begin
      acc_next = dm_rdata;
      pc_next  = pc + PCW'(1);
    end
  end

  assign pm_we = cmd.exec && item_q.kind == KIND_PWRITE && p_in_range;

  always_comb begin
    dm_we    = 1'b0;
    dm_waddr = AW_D'(item_q.address);
    dm_wdata = val_w;
    if (cmd.clr) begin
      dm_we    = 1'b1;
      dm_waddr = clr_cnt;
      dm_wdata = '0;
    end else if (cmd.exec && item_q.kind == KIND_DWRITE && d_in_range) begin
      dm_we = 1'b1;
    end else if (cmd.exec && store_ok) begin
      dm_we    = 1'b1;
      dm_waddr = AW_D'(arg);
      dm_wdata = acc;
    end
  end

  assign dm_raddr = cmd.load_rd ? AW_D'(arg) : AW_D'(req_item.address);

  amt_ram #(.WIDTH(PWW), .DEPTH(PROGRAM_DEPTH)) u_prog_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (AW_P'(item_q.address)),
    .wdata ({item_q.opcode, val_w}),
    .re    (cmd.take),
    .raddr (pc[AW_P-1:0]),
    .rdata (pm_rdata)
  );

  amt_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (cmd.take || cmd.load_rd),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pc      <= '0;
      halted  <= 1'b1;
      status  <= STOP_RUN;
      plen    <= PLEN_RESET;
      clr_cnt <= '0;
    end else begin
      if (cfg_we) begin
        plen <= cfg_wdata;
      end
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + AW_D'(1);
      end
      if (cmd.exec || cmd.load_wr) begin
        acc    <= acc_next;
        pc     <= pc_next;
        halted <= halted_next;
        status <= status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_q <= req_item;
    end
    if (cmd.exec || cmd.load_wr) begin
      rsp_item.accumulator     <= 32'(acc_next);
      rsp_item.program_counter <= 8'(pc_next);
      rsp_item.halted          <= halted_next;
      rsp_item.stop_status     <= status_next;
      rsp_item.read_data       <= rd_next;
    end
  end

  assign sts.clear_last = clr_cnt == AW_D'(DATA_DEPTH - 1);
  assign sts.need_load  = need_load;

endmodule

@@ sv/amt_ctrl.sv @@
// Controller: clear pass, item sequencing and result register handshake.
module amt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  amt_pkg::sts_t sts,
  output amt_pkg::cmd_t cmd
);
  import amt_pkg::*;

  `include "accumulator_machine_step_top_assert.svh"

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_free;
  logic   push;

  assign out_free  = !out_valid || rsp_ready;
  assign req_ready = state == S_IDLE;
  assign rsp_valid = out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    push       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          if (sts.need_load) begin
            cmd.load_rd = 1'b1;
            state_next  = S_LOAD;
          end else begin
            cmd.exec   = 1'b1;
            push       = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load_wr = 1'b1;
          push        = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `AMT_ASSERT_NOW(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd))
  `AMT_ASSERT_NOW(a_no_overwrite, clk, rst, push, !out_valid || rsp_ready)
  `AMT_ASSERT_NEXT(a_one_at_a_time, clk, rst, cmd.take, !req_ready)
  `AMT_ASSERT_NOW(a_clear_blocks, clk, rst, cmd.clr, !req_ready && !push)

endmodule

@@ sv/accumulator_machine_step_top.sv @@
// Top level of the accumulator machine: controller, datapath and channels.
// Sequence: an accepted item is registered, then executed once the result register is free;
// a load-from-memory step reads the data memory first and completes in a further load state.
// The result is registered, and no new item is taken until the current one has completed.
// Reset: synchronous; a clearing pass then zeroes every data memory word with ready low,
// configuration writes still taken; the machine starts halted.
module accumulator_machine_step_top #(
  parameter int PROGRAM_DEPTH = 256,
  parameter int DATA_DEPTH    = 256,
  parameter int WORD_WIDTH    = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [amt_pkg::CFG_W-1:0] cfg_wdata,
  amt_req_if.sink                   req,
  amt_rsp_if.source                 rsp
);
  import amt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  amt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  amt_dpath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .DATA_DEPTH    (DATA_DEPTH),
    .WORD_WIDTH    (WORD_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_item  (req.item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp_item  (rsp.item)
  );

endmodule
